// ===== design/sor_pkg.sv =====
// shared types and constants for the sigma outlier reject averager
`default_nettype none
package sor_pkg;

    // fixed datapath widths (sized for up to 64 samples)
    localparam int SAMPLE_W  = 16;
    localparam int CNT_W     = 7;
    localparam int SUM_W     = 22;
    localparam int MEAN_W    = 24;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 54;
    localparam int SIG_W     = 28;
    localparam int BND_W     = 30;
    localparam int LVL_W     = 21;
    localparam int STAT_W    = 2;
    localparam int DIV_NUM_W = 54;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_CNT_W = 6;
    localparam int MAXR_W    = 16;
    localparam int TOL_W     = 12;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FAIL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MAX_RANGE = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_FAIL_LIM  = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DIV_START,
        OP_MEAN_CAP,
        OP_VAR_D,
        OP_VAR_MUL,
        OP_VAR_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_BOUNDS,
        OP_INL_CHK,
        OP_EMIT_FAIL,
        OP_EMIT_EMPTY,
        OP_EMIT_LVL
    } t_op;

    // divider operand select
    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_LVL
    } t_div_sel;

    typedef struct packed {
        t_op      op;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic fail_hit;
        logic last_fill;
        logic idx_last;
        logic div_done;
        logic sqrt_done;
        logic inl_zero;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/sor_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module sor_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sor_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [sor_pkg::DIV_DEN_W-1:0] i_den,
    output logic                               o_done,
    output logic [sor_pkg::DIV_NUM_W-1:0]      o_quo
);
    import sor_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_qbit;

    // trial subtraction
    assign w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_qbit  = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ===== design/sor_datapath.sv =====
// sample store, statistics registers, square root and result register
`default_nettype none
module sor_datapath #(
    parameter int SAMPLE_COUNT = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sor_pkg::t_cmd                i_cmd,
    output sor_pkg::t_stat                    o_stat,
    input  wire logic [sor_pkg::SAMPLE_W-1:0] i_sample_mm,
    input  wire logic [sor_pkg::MAXR_W-1:0]   i_max_range_mm,
    input  wire logic [sor_pkg::TOL_W-1:0]    i_range_tolerance_mm,
    input  wire logic [sor_pkg::CNT_W-1:0]    i_failure_limit,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic [sor_pkg::LVL_W-1:0]         o_level_cm_q8,
    output logic [sor_pkg::STAT_W-1:0]        o_status,
    output logic [sor_pkg::CNT_W-1:0]         o_inlier_count
);
    import sor_pkg::*;

    localparam int FCW = $clog2(SAMPLE_COUNT + 1);
    localparam int IW  = $clog2(SAMPLE_COUNT);

    logic [SAMPLE_W-1:0] mem [SAMPLE_COUNT];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [FCW-1:0]      r_fill;
    logic [CNT_W-1:0]    r_inv;
    logic [SUM_W-1:0]    r_sum;
    logic [IW-1:0]       r_idx;
    logic [MEAN_W-1:0]   r_mean;
    logic [MEAN_W-1:0]   r_d;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_sq_v;
    logic [ACC_W-1:0]    r_sq_res;
    logic [ACC_W-1:0]    r_sq_bit;
    logic signed [BND_W-1:0] r_lo;
    logic signed [BND_W-1:0] r_hi;
    logic [CNT_W-1:0]    r_inl_n;
    logic [SUM_W-1:0]    r_inl_sum;
    logic                r_out_valid;
    logic [LVL_W-1:0]    r_level;
    logic [STAT_W-1:0]   r_status;
    logic [CNT_W-1:0]    r_inl_cnt;

    logic                    w_invalid;
    logic [CNT_W-1:0]        w_inv_next;
    logic signed [17:0]      w_thr;
    logic [MEAN_W-1:0]       w_s_q8;
    logic [ACC_W-1:0]        w_sq_try;
    logic [SIG_W-1:0]        w_sigma;
    logic signed [BND_W-1:0] w_s_bnd;
    logic                    w_inlier;
    logic                    w_out_free;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [DIV_NUM_W-1:0]    w_div_num;
    logic [DIV_DEN_W-1:0]    w_div_den;
    logic [DIV_NUM_W-1:0]    w_quo;

    // sample classification
    assign w_thr      = $signed({2'b0, i_max_range_mm}) - $signed({6'b0, i_range_tolerance_mm});
    assign w_invalid  = (i_sample_mm == '0) || ($signed({2'b0, i_sample_mm}) >= w_thr);
    assign w_inv_next = r_inv + 1'b1;

    // stored sample scaled to q8
    assign w_s_q8  = {r_rdata, 8'b0};
    assign w_s_bnd = $signed({6'b0, w_s_q8});
    assign w_inlier = (w_s_bnd >= r_lo) && (w_s_bnd <= r_hi);

    assign w_sq_try = r_sq_res + r_sq_bit;
    assign w_sigma  = r_sq_res[SIG_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;

    // divider operands
    assign w_div_start = (i_cmd.op == OP_DIV_START);
    always_comb begin
        case (i_cmd.div_sel)
            DIV_MEAN: begin
                w_div_num = DIV_NUM_W'({r_sum, 8'b0});
                w_div_den = DIV_DEN_W'(SAMPLE_COUNT);
            end
            DIV_VAR: begin
                w_div_num = r_acc;
                w_div_den = DIV_DEN_W'(SAMPLE_COUNT);
            end
            DIV_LVL: begin
                w_div_num = DIV_NUM_W'({r_inl_sum, 8'b0});
                w_div_den = DIV_DEN_W'({r_inl_n, 3'b0}) + DIV_DEN_W'({r_inl_n, 1'b0});
            end
            default: begin
                w_div_num = '0;
                w_div_den = '0;
            end
        endcase
    end

    sor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // sample memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT && !(w_invalid && w_inv_next >= i_failure_limit)) begin
            mem[r_fill[IW-1:0]] <= i_sample_mm;
        end
        r_rdata <= mem[r_idx];
    end

    // collection counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_inv  <= '0;
            r_sum  <= '0;
        end else begin
            case (i_cmd.op)
                OP_ACCEPT: begin
                    if (w_invalid && w_inv_next >= i_failure_limit) begin
                        r_fill <= '0;
                        r_inv  <= '0;
                        r_sum  <= '0;
                    end else begin
                        if (w_invalid) begin
                            r_inv <= w_inv_next;
                        end
                        r_fill <= r_fill + 1'b1;
                        r_sum  <= r_sum + SUM_W'(i_sample_mm);
                    end
                end
                OP_EMIT_EMPTY, OP_EMIT_LVL: begin
                    r_fill <= '0;
                    r_inv  <= '0;
                    r_sum  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // statistics passes and square root
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MEAN_CAP: begin
                r_mean <= w_quo[MEAN_W-1:0];
                r_idx  <= '0;
                r_acc  <= '0;
            end
            OP_VAR_D: begin
                r_d <= (w_s_q8 >= r_mean) ? (w_s_q8 - r_mean) : (r_mean - w_s_q8);
            end
            OP_VAR_MUL: begin
                r_prod <= r_d * r_d;
            end
            OP_VAR_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
                r_idx <= r_idx + 1'b1;
            end
            OP_SQRT_INIT: begin
                r_sq_v   <= w_quo;
                r_sq_res <= '0;
                r_sq_bit <= ACC_W'(1) << (ACC_W - 2);
            end
            OP_SQRT_STEP: begin
                if (r_sq_v >= w_sq_try) begin
                    r_sq_v   <= r_sq_v - w_sq_try;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            OP_BOUNDS: begin
                r_lo      <= $signed({6'b0, r_mean}) - $signed({2'b0, w_sigma});
                r_hi      <= $signed({6'b0, r_mean}) + $signed({2'b0, w_sigma});
                r_idx     <= '0;
                r_inl_n   <= '0;
                r_inl_sum <= '0;
            end
            OP_INL_CHK: begin
                if (w_inlier) begin
                    r_inl_n   <= r_inl_n + 1'b1;
                    r_inl_sum <= r_inl_sum + SUM_W'(r_rdata);
                end
                r_idx <= r_idx + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_EMIT_FAIL, OP_EMIT_EMPTY, OP_EMIT_LVL: r_out_valid <= 1'b1;
                default: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_EMIT_FAIL: begin
                r_level   <= '0;
                r_status  <= STATUS_FAIL;
                r_inl_cnt <= '0;
            end
            OP_EMIT_EMPTY: begin
                r_level   <= '0;
                r_status  <= STATUS_EMPTY;
                r_inl_cnt <= '0;
            end
            OP_EMIT_LVL: begin
                r_level   <= w_quo[LVL_W-1:0];
                r_status  <= STATUS_OK;
                r_inl_cnt <= r_inl_n;
            end
            default: begin
            end
        endcase
    end

    // status to controller
    assign o_stat.fail_hit  = w_invalid && (w_inv_next >= i_failure_limit);
    assign o_stat.last_fill = (r_fill == FCW'(SAMPLE_COUNT - 1));
    assign o_stat.idx_last  = (r_idx == IW'(SAMPLE_COUNT - 1));
    assign o_stat.div_done  = w_div_done;
    assign o_stat.sqrt_done = (r_sq_bit == '0);
    assign o_stat.inl_zero  = (r_inl_n == '0);
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid    = r_out_valid;
    assign o_level_cm_q8  = r_level;
    assign o_status       = r_status;
    assign o_inlier_count = r_inl_cnt;
endmodule
`default_nettype wire

// ===== design/sor_ctrl.sv =====
// controller state machine sequencing collection and the finishing passes
`default_nettype none
module sor_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire sor_pkg::t_stat i_stat,
    output sor_pkg::t_cmd       o_cmd
);
    import sor_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE      = 19'b0000000000000000001,
        S_FAIL      = 19'b0000000000000000010,
        S_MEAN_GO   = 19'b0000000000000000100,
        S_MEAN_WAIT = 19'b0000000000000001000,
        S_V_RD      = 19'b0000000000000010000,
        S_V_D       = 19'b0000000000000100000,
        S_V_MUL     = 19'b0000000000001000000,
        S_V_ACC     = 19'b0000000000010000000,
        S_VAR_GO    = 19'b0000000000100000000,
        S_VAR_WAIT  = 19'b0000000001000000000,
        S_SQRT      = 19'b0000000010000000000,
        S_BOUNDS    = 19'b0000000100000000000,
        S_I_RD      = 19'b0000001000000000000,
        S_I_CHK     = 19'b0000010000000000000,
        S_I_END     = 19'b0000100000000000000,
        S_LVL_GO    = 19'b0001000000000000000,
        S_LVL_WAIT  = 19'b0010000000000000000,
        S_OUT_LVL   = 19'b0100000000000000000,
        S_EMPTY     = 19'b1000000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.div_sel = DIV_MEAN;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_stat.fail_hit) begin
                        n_state = S_FAIL;
                    end else if (i_stat.last_fill) begin
                        n_state = S_MEAN_GO;
                    end
                end
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_FAIL;
                    n_state  = S_IDLE;
                end
            end
            S_MEAN_GO: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_MEAN_CAP;
                    n_state  = S_V_RD;
                end
            end
            S_V_RD:  n_state = S_V_D;
            S_V_D: begin
                o_cmd.op = OP_VAR_D;
                n_state  = S_V_MUL;
            end
            S_V_MUL: begin
                o_cmd.op = OP_VAR_MUL;
                n_state  = S_V_ACC;
            end
            S_V_ACC: begin
                o_cmd.op = OP_VAR_ACC;
                n_state  = i_stat.idx_last ? S_VAR_GO : S_V_RD;
            end
            S_VAR_GO: begin
                o_cmd.op      = OP_DIV_START;
                o_cmd.div_sel = DIV_VAR;
                n_state       = S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_SQRT_INIT;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_BOUNDS;
                end else begin
                    o_cmd.op = OP_SQRT_STEP;
                end
            end
            S_BOUNDS: begin
                o_cmd.op = OP_BOUNDS;
                n_state  = S_I_RD;
            end
            S_I_RD:  n_state = S_I_CHK;
            S_I_CHK: begin
                o_cmd.op = OP_INL_CHK;
                n_state  = i_stat.idx_last ? S_I_END : S_I_RD;
            end
            S_I_END: n_state = i_stat.inl_zero ? S_EMPTY : S_LVL_GO;
            S_LVL_GO: begin
                o_cmd.op      = OP_DIV_START;
                o_cmd.div_sel = DIV_LVL;
                n_state       = S_LVL_WAIT;
            end
            S_LVL_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT_LVL;
                end
            end
            S_OUT_LVL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_LVL;
                    n_state  = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_EMPTY;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/sigma_outlier_reject_average.sv =====
// top level: configuration registers, controller and datapath
`default_nettype none
// Collects SAMPLE_COUNT range samples in millimetres and reports the mean of
// those within one standard deviation of the mean, in centimetres with 8
// fraction bits. The sample that completes a measurement starts the finishing
// sequence: divisions on a serial divider at one quotient bit per cycle for the
// mean, the variance and, unless no sample is an inlier, the level; a variance
// pass per sample (read, difference, multiply, accumulate) and an inlier pass
// per sample (read, check) over the single read port of the sample memory; and
// a 27 step square root. A failure-limit abort emits a fail result once the
// output register is free. Results wait in an output register; no new sample
// is taken until the pending result has been placed.
module sigma_outlier_reject_average #(
    parameter int SAMPLE_COUNT = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_sample_mm,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [20:0]      o_level_cm_q8,
    output logic [1:0]       o_status,
    output logic [6:0]       o_inlier_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sor_pkg::*;

    logic [MAXR_W-1:0] r_max_range;
    logic [TOL_W-1:0]  r_tolerance;
    logic [CNT_W-1:0]  r_fail_lim;
    logic              w_wr;
    t_cmd              w_cmd;
    t_stat             w_stat;

    // configuration write
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MAXR_W'(5000);
            r_tolerance <= TOL_W'(100);
            r_fail_lim  <= CNT_W'(3);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MAX_RANGE: r_max_range <= pwdata[MAXR_W-1:0];
                REG_TOLERANCE: r_tolerance <= pwdata[TOL_W-1:0];
                REG_FAIL_LIM:  r_fail_lim  <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // configuration read
    always_comb begin
        case (paddr[3:2])
            REG_MAX_RANGE: prdata = 32'(r_max_range);
            REG_TOLERANCE: prdata = 32'(r_tolerance);
            REG_FAIL_LIM:  prdata = 32'(r_fail_lim);
            default:       prdata = '0;
        endcase
    end

    sor_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sor_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_sample_mm          (i_sample_mm),
        .i_max_range_mm       (r_max_range),
        .i_range_tolerance_mm (r_tolerance),
        .i_failure_limit      (r_fail_lim),
        .i_out_stall          (i_stall),
        .o_out_valid          (o_valid),
        .o_level_cm_q8        (o_level_cm_q8),
        .o_status             (o_status),
        .o_inlier_count       (o_inlier_count)
    );
endmodule
`default_nettype wire
